FILE: hw/rtl/lser_pkg.sv
package lser_pkg;

    localparam int DEF_MAX_LEN = 1024;

    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [31:0] Q30_HALF = 32'h2000_0000;
    localparam logic [31:0] Q30_LN2 = 32'd744261118;
    localparam logic [32:0] FLUSH_LIMIT = 33'h0_0020_0000;
    localparam logic [4:0] EXP_TERMS = 5'd12;
    localparam logic [4:0] LN_TERMS = 5'd12;
    localparam logic [4:0] SQUARINGS = 5'd5;
    localparam logic [4:0] DIV_STEPS = 5'd30;

    // floor(2^31 / d); a product with this value gives the quotient or one less.
    function automatic logic [31:0] recip(input logic [4:0] d);
        logic [31:0] r;
        begin
            case (d)
                5'd1: r = 32'd2147483648;
                5'd2: r = 32'd1073741824;
                5'd3: r = 32'd715827882;
                5'd4: r = 32'd536870912;
                5'd5: r = 32'd429496729;
                5'd6: r = 32'd357913941;
                5'd7: r = 32'd306783378;
                5'd8: r = 32'd268435456;
                5'd9: r = 32'd238609294;
                5'd10: r = 32'd214748364;
                5'd11: r = 32'd195225786;
                5'd12: r = 32'd178956970;
                5'd13: r = 32'd165191049;
                5'd15: r = 32'd143165576;
                5'd17: r = 32'd126322567;
                5'd19: r = 32'd113025455;
                5'd21: r = 32'd102261126;
                5'd23: r = 32'd93368854;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/log_sum_exp_reduce_core.sv
// Log-sum-exp over a vector of signed Q16.16 samples. Samples arrive one per
// transfer and are written into a sample RAM of MAX_LEN entries at one per
// cycle, while the running maximum is kept in a register. The transfer that
// carries last closes the vector: the input then stalls while a pass reads the
// RAM back one entry at a time through its registered read port. An element
// whose difference to the maximum is zero or below -32 (flushed) skips the
// exponential; otherwise exp(-u) is evaluated by a 12-step Horner loop on one
// shared 32x32 multiplier (each step: the product, a reciprocal multiply for
// the divide by n, and a correction) and five squarings. After the pass the
// logarithm halves the sum k times, until it is below 2.0; a 30-step
// restoring divider then forms z, and 12 series terms run on the same
// multiplier. The result is presented as one transfer carrying max + ln(sum),
// saturated at the Q16.16 maximum, and overflowed when samples beyond MAX_LEN
// were dropped; a new vector may be loaded as soon as the result is registered,
// even while it waits to be taken.
module log_sum_exp_reduce_core #(
    parameter int MAX_LEN = lser_pkg::DEF_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_lse_value,
    output logic        o_overflowed
);

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    // The sum of up to MAX_LEN terms of at most 1.0 in Q.30.
    localparam int SUM_W = 31 + CNT_W;
    localparam int KLN_W = 31 + $clog2(SUM_W + 1);
    localparam int LSUM_W = 34;
    localparam int LNV_W = KLN_W + 5;
    localparam int RES_W = LNV_W + 1;

    localparam logic [4:0] S_LOAD = 5'd0;
    localparam logic [4:0] S_RD = 5'd1;
    localparam logic [4:0] S_FETCH = 5'd2;
    localparam logic [4:0] S_MUL = 5'd3;
    localparam logic [4:0] S_REC = 5'd4;
    localparam logic [4:0] S_COR = 5'd5;
    localparam logic [4:0] S_SQ = 5'd6;
    localparam logic [4:0] S_SQW = 5'd7;
    localparam logic [4:0] S_ADD = 5'd8;
    localparam logic [4:0] S_NORM = 5'd9;
    localparam logic [4:0] S_DIV = 5'd10;
    localparam logic [4:0] S_Z2 = 5'd11;
    localparam logic [4:0] S_Z2W = 5'd12;
    localparam logic [4:0] S_LMUL = 5'd13;
    localparam logic [4:0] S_LCOR = 5'd14;
    localparam logic [4:0] S_LPOW = 5'd15;
    localparam logic [4:0] S_FIN = 5'd16;

    logic [4:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic signed [31:0]  r_max, n_max;
    logic                r_drop, n_drop;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [4:0]          r_step, n_step;
    logic [30:0]         r_g, n_g;
    logic [30:0]         r_acc, n_acc;
    logic [31:0]         r_phi, n_phi;
    logic [63:0]         r_prod;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SUM_W-1:0]    r_m, n_m;
    logic [KLN_W-1:0]    r_kln, n_kln;
    logic [31:0]         r_rem, n_rem;
    logic [31:0]         r_den, n_den;
    logic [29:0]         r_z, n_z;
    logic [29:0]         r_z2, n_z2;
    logic [29:0]         r_p, n_p;
    logic [LSUM_W-1:0]   r_lsum, n_lsum;
    logic                r_out_valid, n_out_valid;
    logic [31:0]         r_out_value, n_out_value;
    logic                r_out_ovf, n_out_ovf;

    logic [31:0]         mul_a, mul_b;
    logic                in_xfer, can_store, fin_go;
    logic                ram_re;
    logic [31:0]         ram_rdata;
    logic signed [32:0]  diff;
    logic [32:0]         u_val;
    logic [31:0]         q0, div_num, rem_val, q_val;
    logic [4:0]          div_d;
    logic [36:0]         q0d;
    logic [63:0]         sq_rnd;
    logic [SUM_W-1:0]    sum_new;
    logic [32:0]         div_sh;
    logic [LNV_W-1:0]    lnv, lnv_rnd;
    logic [RES_W-1:0]    delta;
    logic signed [RES_W-1:0] res;
    logic                sat_hi;

    assign in_xfer = i_valid && o_ready;
    assign can_store = (r_count < CNT_W'(MAX_LEN));
    assign fin_go = !r_out_valid || i_ready;
    assign ram_re = (r_state == S_RD);

    lser_ram #(
        .WIDTH(32),
        .DEPTH(MAX_LEN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (in_xfer && can_store),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(i_sample),
        .i_re   (ram_re),
        .i_raddr(r_idx[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // The single shared multiplier. Its product is always registered and the
    // following state consumes it.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                mul_a = {1'b0, r_g};
                mul_b = {1'b0, r_acc};
            end
            S_REC: begin
                mul_a = r_prod[61:30];
                mul_b = lser_pkg::recip(r_step);
            end
            S_SQ: begin
                mul_a = {1'b0, r_acc};
                mul_b = {1'b0, r_acc};
            end
            S_Z2: begin
                mul_a = {2'b0, r_z};
                mul_b = {2'b0, r_z};
            end
            S_LMUL: begin
                mul_a = {2'b0, r_p};
                mul_b = lser_pkg::recip({r_step[3:0], 1'b1});
            end
            S_LCOR: begin
                mul_a = {2'b0, r_p};
                mul_b = {2'b0, r_z2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Reciprocal quotient is exact or one short; one compare fixes it.
    always_comb begin
        q0 = r_prod[62:31];
        if (r_state == S_COR) begin
            div_num = r_phi;
            div_d = r_step;
        end else begin
            div_num = {2'b0, r_p};
            div_d = {r_step[3:0], 1'b1};
        end
        q0d = 37'(q0) * 37'(div_d);
        rem_val = div_num - q0d[31:0];
        q_val = q0 + {31'b0, (rem_val >= {27'b0, div_d})};
    end

    always_comb begin
        diff = $signed({r_max[31], r_max}) - $signed({ram_rdata[31], ram_rdata});
        u_val = diff;
        sq_rnd = r_prod + {32'b0, lser_pkg::Q30_HALF};
        sum_new = r_sum + SUM_W'(r_acc);
        div_sh = {r_rem, 1'b0};
        lnv = LNV_W'(r_kln) + LNV_W'({r_lsum, 1'b0});
        lnv_rnd = lnv + LNV_W'(14'h2000);
        delta = RES_W'(lnv_rnd >> 14);
        res = $signed({{(RES_W-32){r_max[31]}}, r_max}) + $signed(delta);
        sat_hi = (res > $signed({{(RES_W-31){1'b0}}, 31'h7FFF_FFFF}));
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_max = r_max;
        n_drop = r_drop;
        n_idx = r_idx;
        n_step = r_step;
        n_g = r_g;
        n_acc = r_acc;
        n_phi = r_phi;
        n_sum = r_sum;
        n_m = r_m;
        n_kln = r_kln;
        n_rem = r_rem;
        n_den = r_den;
        n_z = r_z;
        n_z2 = r_z2;
        n_p = r_p;
        n_lsum = r_lsum;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_out_ovf = r_out_ovf;

        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (can_store) begin
                        n_count = r_count + CNT_W'(1);
                        if ($signed(i_sample) > r_max) begin
                            n_max = i_sample;
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_idx = '0;
                        n_sum = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (u_val == '0) begin
                    n_acc = lser_pkg::Q30_ONE[30:0];
                    n_state = S_ADD;
                end else if (u_val > lser_pkg::FLUSH_LIMIT) begin
                    n_acc = '0;
                    n_state = S_ADD;
                end else begin
                    n_g = {u_val[21:0], 9'b0};
                    n_acc = lser_pkg::Q30_ONE[30:0];
                    n_step = lser_pkg::EXP_TERMS;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_REC;
            end
            S_REC: begin
                n_phi = r_prod[61:30];
                n_state = S_COR;
            end
            S_COR: begin
                n_acc = lser_pkg::Q30_ONE[30:0] - q_val[30:0];
                if (r_step == 5'd1) begin
                    n_step = '0;
                    n_state = S_SQ;
                end else begin
                    n_step = r_step - 5'd1;
                    n_state = S_MUL;
                end
            end
            S_SQ: begin
                n_state = S_SQW;
            end
            S_SQW: begin
                n_acc = sq_rnd[60:30];
                n_step = r_step + 5'd1;
                if (r_step == lser_pkg::SQUARINGS - 5'd1) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_ADD: begin
                n_sum = sum_new;
                n_idx = r_idx + CNT_W'(1);
                if (n_idx == r_count) begin
                    n_m = (sum_new < SUM_W'(lser_pkg::Q30_ONE)) ?
                          SUM_W'(lser_pkg::Q30_ONE) : sum_new;
                    n_kln = '0;
                    n_state = S_NORM;
                end else begin
                    n_state = S_RD;
                end
            end
            S_NORM: begin
                if (r_m >= SUM_W'(33'h0_8000_0000)) begin
                    n_m = r_m >> 1;
                    n_kln = r_kln + KLN_W'(lser_pkg::Q30_LN2);
                end else begin
                    n_rem = {2'b0, r_m[29:0]};
                    n_den = {1'b0, r_m[30:0]} + lser_pkg::Q30_ONE;
                    n_z = '0;
                    n_step = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sh >= {1'b0, r_den}) begin
                    n_rem = 32'(div_sh - {1'b0, r_den});
                    n_z = {r_z[28:0], 1'b1};
                end else begin
                    n_rem = div_sh[31:0];
                    n_z = {r_z[28:0], 1'b0};
                end
                n_step = r_step + 5'd1;
                if (r_step == lser_pkg::DIV_STEPS - 5'd1) begin
                    n_state = S_Z2;
                end
            end
            S_Z2: begin
                n_state = S_Z2W;
            end
            S_Z2W: begin
                n_z2 = r_prod[59:30];
                n_p = r_z;
                n_step = '0;
                n_lsum = '0;
                n_state = S_LMUL;
            end
            S_LMUL: begin
                n_state = S_LCOR;
            end
            S_LCOR: begin
                n_lsum = r_lsum + LSUM_W'(q_val);
                n_state = S_LPOW;
            end
            S_LPOW: begin
                n_p = r_prod[59:30];
                if (r_step == lser_pkg::LN_TERMS - 5'd1) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 5'd1;
                    n_state = S_LMUL;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_out_valid = 1'b1;
                    n_out_value = sat_hi ? 32'h7FFF_FFFF : res[31:0];
                    n_out_ovf = r_drop;
                    n_count = '0;
                    n_max = 32'sh8000_0000;
                    n_drop = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_max <= 32'sh8000_0000;
            r_drop <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max <= n_max;
            r_drop <= n_drop;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_step <= n_step;
        r_g <= n_g;
        r_acc <= n_acc;
        r_phi <= n_phi;
        r_prod <= 64'(mul_a) * 64'(mul_b);
        r_sum <= n_sum;
        r_m <= n_m;
        r_kln <= n_kln;
        r_rem <= n_rem;
        r_den <= n_den;
        r_z <= n_z;
        r_z2 <= n_z2;
        r_p <= n_p;
        r_lsum <= n_lsum;
        r_out_value <= n_out_value;
        r_out_ovf <= n_out_ovf;
    end

    assign o_ready = (r_state == S_LOAD);
    assign o_valid = r_out_valid;
    assign o_lse_value = r_out_value;
    assign o_overflowed = r_out_ovf;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("sample count beyond store capacity");

    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_idx < r_count))
        else $error("pass reads a store entry that was not written");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && fin_go) |=> (r_count == '0 && o_valid && o_ready))
        else $error("result not registered or vector not cleared");

    a_term_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_acc <= lser_pkg::Q30_ONE[30:0]))
        else $error("exponential term above one");
`endif

endmodule

FILE: hw/rtl/lser_ram.sv
module lser_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
